### hw/rtl/packed_bitmap_line_expander_assert.svh
// Assertion macros shared by the expander RTL.
// Each expects clk_i and rst_ni in scope.
`ifndef PACKED_BITMAP_LINE_EXPANDER_ASSERT_SVH
`define PACKED_BITMAP_LINE_EXPANDER_ASSERT_SVH

// Same-cycle implication.
`define PBLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PBLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pble_pkg.sv
`timescale 1ns / 1ps

package pble_pkg;

  localparam int LANES      = 8;
  localparam int LANE_AW    = $clog2(LANES);
  localparam int PAL_DEPTH  = 256;
  localparam int PAL_AW     = $clog2(PAL_DEPTH);
  localparam int INDEX_BITS = 16;
  localparam int MAX_LINE   = 1024;
  localparam int LINE_W     = 11;
  localparam int COL_W      = 11;
  localparam int SCOL_W     = 10;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 11;
  localparam int CNT_W      = 4;

  // Bits per pixel codes; anything above the 16 bpp code acts as 16 bpp.
  localparam logic [2:0] DEPTH_1BPP  = 3'd0;
  localparam logic [2:0] DEPTH_2BPP  = 3'd1;
  localparam logic [2:0] DEPTH_4BPP  = 3'd2;
  localparam logic [2:0] DEPTH_8BPP  = 3'd3;
  localparam logic [2:0] DEPTH_16BPP = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] CFG_DEPTH     = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_TRANSP    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_INVERT    = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_PAL_EN    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_WIDTH     = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_START_OFF = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_START_COL = 3'd6;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_UNIT      = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_LEAVE  = 2'd1,
    ACT_INVERT = 2'd2
  } act_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  palette_slot;
    logic [15:0] palette_color;
    logic [15:0] source_unit;
  } pble_in_t;

  typedef struct packed {
    act_e        action;
    logic [15:0] pixel_value;
    logic [10:0] column;
    logic        unit_last;
    logic        line_end;
  } pble_out_t;

  // What one lane found for its pixel position.
  typedef struct packed {
    act_e                  action;
    logic                  use_pal;
    logic [INDEX_BITS-1:0] value;
  } pble_lane_t;

  // One accepted item as handed to the emitter.
  typedef struct packed {
    logic                        is_wr;
    logic [PAL_AW-1:0]           slot;
    logic [INDEX_BITS-1:0]       color;
    logic [LANES-1:0]            mask;
    pble_lane_t [LANES-1:0]      lanes;
    logic [COL_W-1:0]            col;
    logic                        line_done;
  } pble_desc_t;

  // Pixel waiting on the palette read.
  typedef struct packed {
    act_e                  action;
    logic                  use_pal;
    logic [INDEX_BITS-1:0] value;
    logic [COL_W-1:0]      column;
    logic                  unit_last;
    logic                  line_end;
  } pble_pix_t;

endpackage

### hw/rtl/pble_ram.sv
`timescale 1ns / 1ps

module pble_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pble_lane.sv
`timescale 1ns / 1ps

module pble_lane (
  input  logic [pble_pkg::LANE_AW-1:0] lane_idx_i,
  input  logic [15:0]                  unit_i,
  input  logic [2:0]                   depth_i,
  input  logic                         transp_i,
  input  logic                         invert_i,
  input  logic                         pal_en_i,
  output pble_pkg::pble_lane_t         lane_o
);
  import pble_pkg::*;

  logic [2:0]            sh;
  logic [7:0]            field_mask;
  logic [7:0]            shifted;
  logic                  wide;
  logic                  one_bpp;
  logic                  pal_depth;
  logic [INDEX_BITS-1:0] raw;
  logic                  xor_mode;

  always_comb begin
    sh         = 3'd0;
    field_mask = 8'hff;
    wide       = 1'b0;
    one_bpp    = 1'b0;
    pal_depth  = 1'b1;
    unique case (depth_i)
      DEPTH_1BPP: begin
        sh         = 3'd7 - lane_idx_i;
        field_mask = 8'h01;
        one_bpp    = 1'b1;
      end
      DEPTH_2BPP: begin
        sh         = 3'd6 - {lane_idx_i[1:0], 1'b0};
        field_mask = 8'h03;
      end
      DEPTH_4BPP: begin
        sh         = 3'd4 - {lane_idx_i[0], 2'b00};
        field_mask = 8'h0f;
      end
      DEPTH_8BPP: begin
        sh         = 3'd0;
        field_mask = 8'hff;
      end
      default: begin
        wide      = 1'b1;
        pal_depth = 1'b0;
      end
    endcase

    shifted = (unit_i[7:0] >> sh) & field_mask;
    raw     = wide ? unit_i[INDEX_BITS-1:0] : INDEX_BITS'(shifted);

    // Transparent wins over XOR when both are set.
    xor_mode = one_bpp && invert_i && !transp_i;

    lane_o.action  = ACT_WRITE;
    lane_o.use_pal = 1'b0;
    lane_o.value   = '0;
    if (xor_mode) begin
      lane_o.action = (raw != '0) ? ACT_INVERT : ACT_LEAVE;
    end else if (transp_i && raw == '0) begin
      lane_o.action = ACT_LEAVE;
    end else begin
      lane_o.use_pal = one_bpp || (pal_depth && pal_en_i);
      lane_o.value   = raw;
    end
  end

endmodule

### hw/rtl/pble_emit.sv
`timescale 1ns / 1ps
`include "packed_bitmap_line_expander_assert.svh"

module pble_emit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   desc_valid_i,
  input  pble_pkg::pble_desc_t   desc_i,
  output logic                   desc_ready_o,
  output logic                   out_valid_o,
  output pble_pkg::pble_out_t    out_item_o,
  input  logic                   out_stall_i
);
  import pble_pkg::*;

  pble_desc_t            desc_q;
  logic                  desc_valid_q;
  pble_pix_t             pix_q, pix_d;
  logic                  pix_valid_q;
  pble_out_t             out_q;
  logic                  out_valid_q;

  logic                  head_wr;
  logic                  pix_adv;
  logic                  pix_free;
  logic                  issue;
  logic                  last;
  logic                  desc_done;
  logic                  load;
  logic [LANE_AW-1:0]    sel;
  pble_lane_t            sel_lane;
  logic                  ram_re;
  logic [INDEX_BITS-1:0] ram_rdata;

  // Lowest pending pixel position goes first.
  always_comb begin
    sel = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (desc_q.mask[i]) begin
        sel = LANE_AW'(i);
      end
    end
  end

  assign sel_lane  = desc_q.lanes[sel];
  assign last      = (desc_q.mask & (desc_q.mask - LANES'(1))) == '0;
  assign head_wr   = desc_valid_q && desc_q.is_wr;
  assign pix_adv   = pix_valid_q && (!out_valid_q || !out_stall_i);
  assign pix_free  = !pix_valid_q || pix_adv;
  assign issue     = desc_valid_q && !desc_q.is_wr && pix_free;
  assign desc_done = head_wr || (issue && last);
  assign desc_ready_o = !desc_valid_q || desc_done;
  assign load      = desc_valid_i && desc_ready_o;
  assign ram_re    = issue && sel_lane.use_pal;

  pble_ram #(
    .WIDTH (INDEX_BITS),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (head_wr),
    .waddr_i (desc_q.slot),
    .wdata_i (desc_q.color),
    .re_i    (ram_re),
    .raddr_i (sel_lane.value[PAL_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_valid_q <= 1'b0;
    end else if (load) begin
      desc_valid_q <= 1'b1;
    end else if (desc_done) begin
      desc_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      desc_q <= desc_i;
    end else if (issue) begin
      desc_q.mask <= desc_q.mask & (desc_q.mask - LANES'(1));
      desc_q.col  <= desc_q.col + COL_W'(1);
    end
  end

  always_comb begin
    pix_d.action    = sel_lane.action;
    pix_d.use_pal   = sel_lane.use_pal;
    pix_d.value     = sel_lane.value;
    pix_d.column    = desc_q.col;
    pix_d.unit_last = last;
    pix_d.line_end  = last && desc_q.line_done;
  end

  // Pixel stage: palette read data is registered together with the pixel, so the two line up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (issue) begin
      pix_valid_q <= 1'b1;
    end else if (pix_adv) begin
      pix_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pix_q <= pix_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pix_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_adv) begin
      out_q.action      <= pix_q.action;
      out_q.pixel_value <= 16'(pix_q.use_pal ? ram_rdata : pix_q.value);
      out_q.column      <= pix_q.column;
      out_q.unit_last   <= pix_q.unit_last;
      out_q.line_end    <= pix_q.line_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PBLE_ASSERT_NOW(a_unit_has_pixels, desc_valid_q && !desc_q.is_wr, desc_q.mask != '0,
    "data item holds no pixel")
  `PBLE_ASSERT_NOW(a_line_end_closes_unit, out_valid_q && out_q.line_end, out_q.unit_last,
    "line end without unit end")
  `PBLE_ASSERT_NEXT(a_pixel_held_when_blocked, pix_valid_q && !pix_adv, pix_valid_q,
    "pixel stage dropped a blocked pixel")

endmodule

### hw/rtl/packed_bitmap_line_expander.sv
`timescale 1ns / 1ps
`include "packed_bitmap_line_expander_assert.svh"

// Packed bitmap line expander. Each source unit is split by eight parallel
// lanes into up to eight pixels (8/4/2/1/1 at 1/2/4/8/16 bpp); the pixels
// then leave one per cycle, unless the output stalls, through a single
// palette read port. The palette write is taken in order with the pixels,
// so it only affects units accepted after it. The next unit is accepted in
// the cycle the current one issues its last pixel; the first pixel passes
// the descriptor, pixel and output registers before it is presented.
// Palette entries are undefined until written; there is no clearing pass
// after reset. Line width and start offset are sampled when a line begins;
// depth and the drawing modes apply per unit.
module packed_bitmap_line_expander (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  pble_pkg::pble_in_t            in_item_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  output pble_pkg::pble_out_t           out_item_o,
  input  logic                          out_stall_i,
  input  logic                          cfg_we_i,
  input  logic [pble_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  logic [pble_pkg::CFG_DW-1:0]   cfg_data_i
);
  import pble_pkg::*;

  logic [2:0]        depth_q;
  logic              transp_q;
  logic              invert_q;
  logic              pal_en_q;
  logic [LINE_W-1:0] width_q;
  logic [2:0]        start_off_q;
  logic [SCOL_W-1:0] start_col_q;

  logic              line_start_q;
  logic [LINE_W-1:0] left_q;
  logic [COL_W-1:0]  colcnt_q;

  logic              desc_ready;
  logic              accept;
  logic              unit_acc;
  logic [LINE_W-1:0] width_c;
  logic [CNT_W-1:0]  per_unit;
  logic [2:0]        pos;
  logic [CNT_W-1:0]  avail;
  logic [CNT_W-1:0]  count;
  logic [LINE_W-1:0] left;
  logic [LINE_W-1:0] left_after;
  logic [COL_W-1:0]  colcnt;
  logic              line_done;
  pble_desc_t        desc;
  pble_lane_t [LANES-1:0] lanes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= DEPTH_1BPP;
      transp_q    <= 1'b0;
      invert_q    <= 1'b0;
      pal_en_q    <= 1'b0;
      width_q     <= LINE_W'(1);
      start_off_q <= '0;
      start_col_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEPTH:     depth_q     <= cfg_data_i[2:0];
        CFG_TRANSP:    transp_q    <= cfg_data_i[0];
        CFG_INVERT:    invert_q    <= cfg_data_i[0];
        CFG_PAL_EN:    pal_en_q    <= cfg_data_i[0];
        CFG_WIDTH:     width_q     <= cfg_data_i[LINE_W-1:0];
        CFG_START_OFF: start_off_q <= cfg_data_i[2:0];
        CFG_START_COL: start_col_q <= cfg_data_i[SCOL_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pble_lane u_lane (
      .lane_idx_i (LANE_AW'(g)),
      .unit_i     (in_item_i.source_unit),
      .depth_i    (depth_q),
      .transp_i   (transp_q),
      .invert_i   (invert_q),
      .pal_en_i   (pal_en_q),
      .lane_o     (lanes[g])
    );
  end

  always_comb begin
    if (width_q == '0) begin
      width_c = LINE_W'(1);
    end else if (width_q > LINE_W'(MAX_LINE)) begin
      width_c = LINE_W'(MAX_LINE);
    end else begin
      width_c = width_q;
    end

    unique case (depth_q)
      DEPTH_1BPP: per_unit = CNT_W'(8);
      DEPTH_2BPP: per_unit = CNT_W'(4);
      DEPTH_4BPP: per_unit = CNT_W'(2);
      default:    per_unit = CNT_W'(1);
    endcase

    left   = line_start_q ? width_c : left_q;
    colcnt = line_start_q ? '0 : colcnt_q;
    pos    = line_start_q ? (start_off_q & 3'(per_unit - CNT_W'(1))) : 3'd0;
    avail  = per_unit - {1'b0, pos};
    count  = (left < LINE_W'(avail)) ? left[CNT_W-1:0] : avail;
    left_after = left - LINE_W'(count);
    line_done  = left_after == '0;

    desc.is_wr     = in_item_i.op == OP_PAL_WRITE;
    desc.slot      = in_item_i.palette_slot[PAL_AW-1:0];
    desc.color     = in_item_i.palette_color[INDEX_BITS-1:0];
    desc.lanes     = lanes;
    desc.col       = COL_W'(start_col_q) + colcnt;
    desc.line_done = line_done;
    for (int i = 0; i < LANES; i++) begin
      desc.mask[i] = (CNT_W'(i) >= {1'b0, pos})
                     && ((CNT_W'(i) - {1'b0, pos}) < count);
    end
  end

  assign in_stall_o = !desc_ready;
  assign accept     = in_valid_i && desc_ready;
  assign unit_acc   = accept && in_item_i.op == OP_UNIT;

  // Line position advances when the unit is taken, not when its pixels leave.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q <= 1'b1;
      left_q       <= LINE_W'(1);
      colcnt_q     <= '0;
    end else if (unit_acc) begin
      if (line_done) begin
        line_start_q <= 1'b1;
        left_q       <= width_c;
        colcnt_q     <= '0;
      end else begin
        line_start_q <= 1'b0;
        left_q       <= left_after;
        colcnt_q     <= colcnt + COL_W'(count);
      end
    end
  end

  pble_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (in_valid_i),
    .desc_i       (desc),
    .desc_ready_o (desc_ready),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o),
    .out_stall_i  (out_stall_i)
  );

  `PBLE_ASSERT_NEXT(a_line_restart, unit_acc && line_done, line_start_q,
    "finished line did not restart")
  `PBLE_ASSERT_NOW(a_mid_line_left, !line_start_q, left_q != '0 && left_q <= LINE_W'(MAX_LINE),
    "pixels left out of range inside a line")

endmodule

### bench/pble_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps its own copy of the
// palette and line state, and checks every pixel against the expanded unit.
module pble_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  pble_pkg::pble_in_t          in_item_i,
  input  logic                        in_stall_i,
  input  logic                        out_valid_i,
  input  pble_pkg::pble_out_t         out_item_i,
  input  logic                        out_stall_i,
  input  logic                        cfg_we_i,
  input  logic [pble_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [pble_pkg::CFG_DW-1:0] cfg_data_i,
  output int                          fail_cnt_o,
  output int                          pending_o,
  output logic                        line_open_o
);
  import pble_pkg::*;

  logic [INDEX_BITS-1:0] pal_mem [PAL_DEPTH];
  logic [2:0]            depth_code;
  logic                  transp_en;
  logic                  invert_en;
  logic                  pal_en;
  logic [LINE_W-1:0]     width_reg;
  logic [2:0]            start_off;
  logic [SCOL_W-1:0]     start_col;
  int                    pixels_left;
  logic [COL_W-1:0]      col_cnt;
  logic                  at_line_start;
  pble_out_t             pixel_q [$];

  function automatic int line_len();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_LINE) return MAX_LINE;
    return int'(width_reg);
  endfunction

  // Split one source unit into its pixels and queue the expected results.
  function automatic void expand_unit(input logic [15:0] unit);
    int          bpp;
    int          per_unit;
    int          pos;
    int          raw;
    logic [15:0] src;
    logic        invert_mode;
    pble_out_t   pix;
    case (depth_code)
      DEPTH_1BPP: bpp = 1;
      DEPTH_2BPP: bpp = 2;
      DEPTH_4BPP: bpp = 4;
      DEPTH_8BPP: bpp = 8;
      default:    bpp = 16;
    endcase
    per_unit = (bpp >= 8) ? 1 : 8 / bpp;
    src = (bpp < 16) ? {8'h00, unit[7:0]} : unit;
    pos = 0;
    if (at_line_start) begin
      pixels_left = line_len();
      col_cnt = '0;
      if (bpp < 8) pos = int'(start_off) & (per_unit - 1);
      at_line_start = 1'b0;
    end
    // transparent wins over invert
    invert_mode = (bpp == 1) && invert_en && !transp_en;
    while (pos < per_unit && pixels_left > 0) begin
      if (bpp >= 16) raw = int'(src);
      else raw = int'(src >> (8 - bpp * (pos + 1))) & ((1 << bpp) - 1);
      pix.pixel_value = '0;
      if (invert_mode) begin
        pix.action = (raw != 0) ? ACT_INVERT : ACT_LEAVE;
      end else if (transp_en && raw == 0) begin
        pix.action = ACT_LEAVE;
      end else begin
        pix.action = ACT_WRITE;
        if (bpp == 1 || (bpp <= 8 && pal_en)) pix.pixel_value = pal_mem[raw % PAL_DEPTH];
        else pix.pixel_value = raw[15:0];
      end
      pixels_left--;
      pix.column = start_col + col_cnt;
      pix.unit_last = (pos + 1 == per_unit) || (pixels_left == 0);
      pix.line_end = (pixels_left == 0);
      col_cnt = col_cnt + 1'b1;
      pos++;
      pixel_q.push_back(pix);
    end
    if (pixels_left == 0) begin
      at_line_start = 1'b1;
      col_cnt = '0;
      pixels_left = line_len();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pble_out_t want;
    logic      bad;
    if (!rst_ni) begin
      depth_code    = DEPTH_1BPP;
      transp_en     = 1'b0;
      invert_en     = 1'b0;
      pal_en        = 1'b0;
      width_reg     = LINE_W'(1);
      start_off     = '0;
      start_col     = '0;
      pixels_left   = 1;
      col_cnt       = '0;
      at_line_start = 1'b1;
      pixel_q.delete();
      fail_cnt_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEPTH:     depth_code = cfg_data_i[2:0];
          CFG_TRANSP:    transp_en = cfg_data_i[0];
          CFG_INVERT:    invert_en = cfg_data_i[0];
          CFG_PAL_EN:    pal_en = cfg_data_i[0];
          CFG_WIDTH:     width_reg = cfg_data_i;
          CFG_START_OFF: start_off = cfg_data_i[2:0];
          CFG_START_COL: start_col = cfg_data_i[SCOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_item_i.op == OP_PAL_WRITE) pal_mem[in_item_i.palette_slot] = in_item_i.palette_color;
        else expand_unit(in_item_i.source_unit);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          if (fail_cnt_o < 10)
            $display("%0t: pixel with none expected: action %0d value %h column %0d",
                     $time, out_item_i.action, out_item_i.pixel_value, out_item_i.column);
          fail_cnt_o++;
        end else begin
          want = pixel_q.pop_front();
          bad = (out_item_i.action !== want.action) ||
                (out_item_i.pixel_value !== want.pixel_value) ||
                (out_item_i.column !== want.column) ||
                (out_item_i.unit_last !== want.unit_last) ||
                (out_item_i.line_end !== want.line_end);
          if (bad) begin
            if (fail_cnt_o < 10) begin
              $display("%0t: pixel mismatch, expected act %0d val %h col %0d last %b end %b",
                       $time, want.action, want.pixel_value, want.column,
                       want.unit_last, want.line_end);
              $display("%0t:                 got      act %0d val %h col %0d last %b end %b",
                       $time, out_item_i.action, out_item_i.pixel_value, out_item_i.column,
                       out_item_i.unit_last, out_item_i.line_end);
            end
            fail_cnt_o++;
          end
        end
      end
    end
    pending_o = pixel_q.size();
    line_open_o = !at_line_start;
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pble_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  pble_in_t          in_item = '0;
  logic              in_stall;
  logic              out_valid;
  pble_out_t         out_item;
  logic              out_stall = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_idx = CFG_DEPTH;
  logic [CFG_DW-1:0] cfg_data = '0;

  int   fail_cnt;
  int   pending;
  logic line_open;
  int   sender_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   holdoff_len = 0;

  packed_bitmap_line_expander dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .out_stall_i (out_stall),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  pble_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .in_stall_i  (in_stall),
    .out_valid_i (out_valid),
    .out_item_i  (out_item),
    .out_stall_i (out_stall),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .line_open_o (line_open)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always begin
    @(negedge clk);
    if (holdoff_len > 0) begin
      out_stall <= 1'b1;
      repeat (holdoff_len) @(negedge clk);
      holdoff_len = 0;
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic pble_in_t unit_item(input logic [15:0] src);
    pble_in_t it;
    it.op            = OP_UNIT;
    it.palette_slot  = 8'($urandom);
    it.palette_color = 16'($urandom);
    it.source_unit   = src;
    return it;
  endfunction

  function automatic pble_in_t pal_item(input logic [7:0] slot, input logic [15:0] color);
    pble_in_t it;
    it.op            = OP_PAL_WRITE;
    it.palette_slot  = slot;
    it.palette_color = color;
    it.source_unit   = 16'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] rand_source();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return {8'($urandom), 8'h00};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    int g;
    g = 0;
    while (g < 40 && $urandom_range(99) < sender_idle_pct) g++;
    return g;
  endfunction

  // Offer one item and hold it until it is taken.
  task automatic push_item(input pble_in_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    release_input();
    while (pending != 0) @(negedge clk);
    // palette writes leave nothing to wait for; give the pipe time to settle
    repeat (12) @(negedge clk);
  endtask

  // Pad the current line with random units so settings change on a boundary.
  task automatic finish_line();
    release_input();
    while (line_open) begin
      push_item(unit_item(rand_source()));
      release_input();
    end
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DW'(val);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic apply_config(input int depth, input int transp, input int invert,
                              input int pal_on, input int width, input int off,
                              input int col);
    finish_line();
    drain();
    write_reg(CFG_DEPTH, depth);
    write_reg(CFG_TRANSP, transp);
    write_reg(CFG_INVERT, invert);
    write_reg(CFG_PAL_EN, pal_on);
    write_reg(CFG_WIDTH, width);
    write_reg(CFG_START_OFF, off);
    write_reg(CFG_START_COL, col);
  endtask

  task automatic random_config(input int phase);
    int depth;
    int width;
    int col;
    depth = $urandom_range(7);
    // short lines keep the padding between phases small
    case ($urandom_range(9))
      0:       width = 0;
      default: width = $urandom_range(1, 24);
    endcase
    case ($urandom_range(3))
      0:       col = 0;
      1:       col = 1023;
      default: col = $urandom_range(1023);
    endcase
    apply_config(depth, $urandom_range(1), $urandom_range(1), $urandom_range(1),
                 width, $urandom_range(7), col);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // load every palette entry so no read ever hits an empty slot
    for (int s = 0; s < PAL_DEPTH; s++) begin
      if (s == 0) push_item(pal_item(8'(s), 16'hFFFF));
      else if (s == PAL_DEPTH - 1) push_item(pal_item(8'(s), 16'h0000));
      else push_item(pal_item(8'(s), 16'($urandom)));
    end

    // plain 1 bpp, high source bits ignored
    apply_config(DEPTH_1BPP, 0, 0, 0, 8, 0, 0);
    push_item(unit_item(16'h00FF));
    push_item(unit_item(16'hFF00));
    push_item(unit_item(16'h00A5));
    // invert drawing, offset into first unit, last column
    apply_config(DEPTH_1BPP, 0, 1, 0, 12, 5, 1023);
    push_item(unit_item(16'h005A));
    push_item(unit_item(16'h00C3));
    push_item(unit_item(16'h0080));
    // transparent and invert together act as transparent
    apply_config(DEPTH_1BPP, 1, 1, 0, 8, 0, 0);
    push_item(unit_item(16'h003C));
    // 2 bpp through the palette, offset masked to the unit
    apply_config(DEPTH_2BPP, 0, 0, 1, 7, 7, 0);
    push_item(unit_item(16'h00E4));
    push_item(unit_item(16'h001B));
    push_item(unit_item(16'h0072));
    // 4 bpp raw with transparency
    apply_config(DEPTH_4BPP, 1, 0, 0, 4, 5, 500);
    push_item(unit_item(16'h00F0));
    push_item(unit_item(16'h000F));
    push_item(unit_item(16'h0090));
    // 8 bpp through the palette; a rewrite only affects later units
    apply_config(DEPTH_8BPP, 0, 0, 1, 2, 7, 0);
    push_item(unit_item(16'h00FF));
    push_item(unit_item(16'h0000));
    push_item(pal_item(8'hFF, 16'h5AA5));
    push_item(unit_item(16'h00FF));
    push_item(unit_item(16'h0001));
    // 16 bpp raw, transparent zero
    apply_config(DEPTH_16BPP, 1, 0, 0, 3, 0, 0);
    push_item(unit_item(16'hFFFF));
    push_item(unit_item(16'h0000));
    push_item(unit_item(16'h8001));
    // depth code above 16 bpp, width zero, invert ignored
    apply_config(7, 0, 1, 1, 0, 3, 1023);
    push_item(unit_item(16'h1234));
    push_item(unit_item(16'hFFFF));

    for (int phase = 0; phase < 12; phase++) begin
      random_config(phase);
      case (phase % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      // hold the output off while the sender keeps going
      if (phase == 2) holdoff_len = 300;
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(9) == 0) push_item(pal_item(8'($urandom), 16'($urandom)));
        else push_item(unit_item(rand_source()));
      end
    end

    drain();
    if (fail_cnt == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/pble_pkg.sv
hw/rtl/pble_ram.sv
hw/rtl/pble_lane.sv
hw/rtl/pble_emit.sv
hw/rtl/packed_bitmap_line_expander.sv
bench/pble_checker.sv
bench/tb_top.sv
